// ===== hdl/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

	localparam int NUM_BUFFERS = 32;
	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

	localparam int BUF_IDX_W = 5;
	localparam int GRANT_W = 5;
	localparam int FREE_W = 6;
	localparam int LEVEL_W = 8;
	localparam int TOTAL_W = 32;
	localparam int LIMIT_W = 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_CONGESTION_LIMIT = 1'b0
	} reg_idx_t;

	typedef struct packed {
		cmd_t cmd;
		logic [BUF_IDX_W-1:0] buffer_index;
	} req_t;

	typedef struct packed {
		logic granted;
		logic [GRANT_W-1:0] grant_index;
		logic [FREE_W-1:0] free_bufs;
		logic congested;
		logic severe_congestion;
		logic [LEVEL_W-1:0] congestion_level;
		logic [TOTAL_W-1:0] alloc_total;
		logic [TOTAL_W-1:0] release_total;
		logic [TOTAL_W-1:0] fail_total;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hdl/bpa_regs.sv =====
`default_nettype none
module bpa_regs import bpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	output logic [LIMIT_W-1:0] limit
);

	logic [LIMIT_W-1:0] limit_q;
	reg_idx_t reg_sel;
	logic sel_ok;

	always_comb begin
		reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
		sel_ok = (paddr[PADDR_W-1:2] == REG_CONGESTION_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && sel_ok) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_CONGESTION_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign limit = limit_q;

endmodule
`default_nettype wire

// ===== hdl/bpa_engine.sv =====
`default_nettype none
module bpa_engine import bpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire req_t req,
	input wire logic [LIMIT_W-1:0] limit,
	output rsp_t rsp
);

	logic [NUM_BUFFERS-1:0] flags_q, flags_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [TOTAL_W-1:0] alloc_q, alloc_d;
	logic [TOTAL_W-1:0] release_q, release_d;
	logic [TOTAL_W-1:0] fail_q, fail_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic congested_q, congested_d;
	logic severe_q, severe_d;

	logic [NUM_BUFFERS-1:0] free_mask;
	logic found;
	logic [IDX_W-1:0] gidx;
	logic in_range;
	logic [IDX_W-1:0] rel_idx;
	logic hit;
	logic [CNT_W-1:0] free_n;

	always_comb begin
		free_mask = ~flags_q;
		found = |free_mask;
		gidx = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				gidx = IDX_W'(i);
			end
		end

		in_range = (32'(req.buffer_index) < 32'(NUM_BUFFERS));
		rel_idx = IDX_W'(req.buffer_index);
		hit = in_range && flags_q[rel_idx];

		flags_d = flags_q;
		used_d = used_q;
		alloc_d = alloc_q;
		release_d = release_q;
		fail_d = fail_q;
		level_d = level_q;
		congested_d = congested_q;
		severe_d = severe_q;

		rsp.granted = 1'b0;
		rsp.grant_index = '0;

		case (req.cmd)
			CMD_ALLOC: begin
				if (found) begin
					flags_d[gidx] = 1'b1;
					used_d = used_q + CNT_W'(1);
					alloc_d = alloc_q + TOTAL_W'(1);
					rsp.granted = 1'b1;
					rsp.grant_index = GRANT_W'(gidx);
				end else begin
					fail_d = fail_q + TOTAL_W'(1);
					congested_d = 1'b1;
					if (level_q != {LEVEL_W{1'b1}}) begin
						level_d = level_q + LEVEL_W'(1);
					end
					if (level_d >= limit) begin
						severe_d = 1'b1;
					end
				end
			end
			CMD_RELEASE: begin
				if (hit) begin
					flags_d[rel_idx] = 1'b0;
					used_d = used_q - CNT_W'(1);
					release_d = release_q + TOTAL_W'(1);
					if (used_d < CNT_W'(NUM_BUFFERS / 2)) begin
						level_d = '0;
					end
				end
			end
			default: begin
			end
		endcase

		free_n = CNT_W'(NUM_BUFFERS) - used_d;
		rsp.free_bufs = FREE_W'(free_n);
		rsp.congested = congested_d;
		rsp.severe_congestion = severe_d;
		rsp.congestion_level = level_d;
		rsp.alloc_total = alloc_d;
		rsp.release_total = release_d;
		rsp.fail_total = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			used_q <= '0;
			alloc_q <= '0;
			release_q <= '0;
			fail_q <= '0;
			level_q <= '0;
			congested_q <= 1'b0;
			severe_q <= 1'b0;
		end else if (advance) begin
			flags_q <= flags_d;
			used_q <= used_d;
			alloc_q <= alloc_d;
			release_q <= release_d;
			fail_q <= fail_d;
			level_q <= level_d;
			congested_q <= congested_d;
			severe_q <= severe_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/buffer_pool_allocator_with_congestion.sv =====
`default_nettype none
// Buffer pool allocator: each request (allocate, or release a named buffer) gives one
// response. A request is registered on acceptance, resolved against the pool state when
// it advances (lowest-free priority encoder, counters and congestion flags updated
// together) and the response is registered at the output, so while the output does not
// stall one request is taken and one response delivered per cycle. A request can be
// accepted while a previous response still waits to be taken.
// The congestion limit register (offset 0, reset 10) is written through the APB port;
// the user must write it only while the block is idle, as the block does not enforce it.
module buffer_pool_allocator_with_congestion import bpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t rsp_d;
	logic advance;
	logic [LIMIT_W-1:0] limit;

	assign advance = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	bpa_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.limit(limit)
	);

	bpa_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.req(req_s1),
		.limit(limit),
		.rsp(rsp_d)
	);

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.severe_congestion |-> rsp.congested)
		else $error("severe congestion without congestion");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.grant_index == '0)
		else $error("grant index set without a grant");

	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("request stalled with empty input stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("resolved request produced no response");
`endif

endmodule
`default_nettype wire
